/* rtl/olist_pkg.sv */
// Package with the shared types and codes of the ordered list block.
package olist_pkg;

	// Operation codes carried by an input transaction.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// Widths of the transaction fields.
	localparam int unsigned OP_W    = 2;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned CNT_W   = 7;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Read address choice relative to the working pointer.
	typedef enum logic [1:0] {
		ADR_PTR     = 2'd0,
		ADR_PTR_DEC = 2'd1,
		ADR_PTR_INC = 2'd2
	} addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      rd;
		addr_sel_t rd_sel;
		logic      wr_shift;
		logic      wr_value;
		logic      ptr_dec;
		logic      ptr_inc;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      set_status;
		status_t   status;
		logic      set_idx;
		logic      res_load;
	} olist_cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic is_insert;
		logic is_search;
		logic is_delete;
		logic full;
		logic ins_badpos;
		logic del_badpos;
		logic ins_more;
		logic del_more;
		logic scan_more;
		logic match;
		logic res_busy;
	} olist_stat_t;

endpackage

/* rtl/olist_in_if.sv */
// Channel interface that carries one list operation.
interface olist_in_if
	import olist_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

/* rtl/olist_out_if.sv */
// Channel interface that carries one operation result.
interface olist_out_if
	import olist_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] found_index;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output status, output found_index, output entry_count,
		input ready);
	modport sink (input valid, input status, input found_index, input entry_count,
		output ready);
endinterface

/* rtl/olist_ctrl.sv */
// Controller state machine that sequences each list operation.
module olist_ctrl
	import olist_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  olist_stat_t stat,
	output olist_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_EXEC     = 9'b000000010,
		S_INS      = 9'b000000100,
		S_INS_WR   = 9'b000001000,
		S_DEL      = 9'b000010000,
		S_DEL_WR   = 9'b000100000,
		S_SRCH     = 9'b001000000,
		S_SRCH_CMP = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.rd_sel = ADR_PTR;
		cmd.status = ST_OK;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_insert) begin
					if (stat.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_FULL;
						state_d        = S_DONE;
					end else if (stat.ins_badpos) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_BADPOS;
						state_d        = S_DONE;
					end else begin
						state_d = S_INS;
					end
				end else if (stat.is_delete) begin
					if (stat.del_badpos) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_BADPOS;
						state_d        = S_DONE;
					end else begin
						state_d = S_DEL;
					end
				end else if (stat.is_search) begin
					state_d = S_SRCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INS: begin
				if (stat.ins_more) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = ADR_PTR_DEC;
					state_d    = S_INS_WR;
				end else begin
					cmd.wr_value   = 1'b1;
					cmd.cnt_inc    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_OK;
					state_d        = S_DONE;
				end
			end
			S_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_dec  = 1'b1;
				state_d      = S_INS;
			end
			S_DEL: begin
				if (stat.del_more) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = ADR_PTR_INC;
					state_d    = S_DEL_WR;
				end else begin
					cmd.cnt_dec    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_OK;
					state_d        = S_DONE;
				end
			end
			S_DEL_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = S_DEL;
			end
			S_SRCH: begin
				if (stat.scan_more) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = ADR_PTR;
					state_d    = S_SRCH_CMP;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOTFOUND;
					state_d        = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					cmd.set_idx    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_OK;
					state_d        = S_DONE;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SRCH;
				end
			end
			S_DONE: begin
				if (!stat.res_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/olist_dp.sv */
// Datapath with the entry memory, count, pointer and result register.
module olist_dp
	import olist_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  olist_cmd_t                cmd,
	output olist_stat_t               stat,
	input  logic [OP_W-1:0]           req_opcode,
	input  logic signed [VALUE_W-1:0] req_value,
	input  logic [POS_W-1:0]          req_position,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [1:0]                rsp_status,
	output logic [IDX_W-1:0]          rsp_found_index,
	output logic [CNT_W-1:0]          rsp_entry_count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

	logic signed [VALUE_W-1:0] mem [DEPTH];

	logic [OP_W-1:0]           op_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [POS_W-1:0]          pos_q;
	logic [CW-1:0]             ptr_q;
	logic [CW-1:0]             count_q;
	logic signed [VALUE_W-1:0] rdata_q;
	status_t                   status_q;
	logic [AW-1:0]             idx_q;
	logic                      out_valid_q;
	status_t                   out_status_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic [CNT_W-1:0]          out_count_q;

	logic [CW-1:0] ptr_init;
	logic [CW:0]   ptr_plus;
	logic [CW-1:0] raddr_full;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	// Starting pointer: top of the list for insert, the position for delete, zero for search.
	always_comb begin
		case (req_opcode)
			OP_INSERT: ptr_init = count_q;
			OP_DELETE: ptr_init = CW'(req_position);
			default:   ptr_init = '0;
		endcase
	end

	assign ptr_plus = (CW + 1)'(ptr_q) + (CW + 1)'(1);

	// Read address relative to the pointer.
	always_comb begin
		case (cmd.rd_sel)
			ADR_PTR_DEC: raddr_full = ptr_q - CW'(1);
			ADR_PTR_INC: raddr_full = ptr_plus[CW-1:0];
			default:     raddr_full = ptr_q;
		endcase
	end

	assign raddr = raddr_full[AW-1:0];
	assign waddr = ptr_q[AW-1:0];

	// Flags for the controller.
	assign stat.is_insert  = (op_q == OP_INSERT);
	assign stat.is_search  = (op_q == OP_SEARCH);
	assign stat.is_delete  = (op_q == OP_DELETE);
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.ins_badpos = (PW'(pos_q) > PW'(count_q));
	assign stat.del_badpos = (PW'(pos_q) >= PW'(count_q));
	assign stat.ins_more   = (PW'(ptr_q) > PW'(pos_q));
	assign stat.del_more   = (ptr_plus < (CW + 1)'(count_q));
	assign stat.scan_more  = (ptr_q < count_q);
	assign stat.match      = (rdata_q == key_q);
	assign stat.res_busy   = out_valid_q && !rsp_ready;

	// Entry memory write port.
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[waddr] <= rdata_q;
		end else if (cmd.wr_value) begin
			mem[waddr] <= key_q;
		end
	end

	// Entry memory read port with registered data.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	// Operation registers captured at acceptance.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_opcode;
			key_q <= req_value;
			pos_q <= req_position;
		end
	end

	// Working pointer, result status and match index.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ptr_q <= ptr_init;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - CW'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_plus[CW-1:0];
		end
		if (cmd.load) begin
			status_q <= ST_OK;
			idx_q    <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.set_idx) begin
				idx_q <= ptr_q[AW-1:0];
			end
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= status_q;
			out_idx_q    <= IDX_W'(idx_q);
			out_count_q  <= CNT_W'(count_q);
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_found_index = out_idx_q;
	assign rsp_entry_count = out_count_q;

endmodule

/* rtl/ordered_list_insert_delete_search.sv */
// Top level of the ordered list with positional insert, delete and key search.
//
// The req channel takes one operation per transaction: opcode (insert, search,
// delete), a signed 32-bit value or search key, and a list position. The rsp
// channel returns exactly one result per operation: status, lowest matching
// index of a search, and the entry count after the operation.
// Entries live in a single-port-write, registered-read memory of DEPTH words,
// so every entry moved or examined goes through that memory one at a time.
// An operation's work grows with the entries it moves (insert: count -
// position, delete: count - position - 1) or examines (a search reads from
// index zero up to its first match, or to the end). Rejected operations and
// the unused opcode go straight to the result. One operation is handled at
// a time; req.ready is high only while idle, so the next transaction can be
// taken in the cycle in which the result shows.
// A result waits in the output register while rsp.ready is low; the next
// operation is then accepted and worked on, and holds in its final state
// until the result register is free.
// Reset empties the list at once; no clearing pass is needed.
module ordered_list_insert_delete_search
	import olist_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	olist_in_if.sink     req,
	olist_out_if.source  rsp
);

	olist_cmd_t  cmd;
	olist_stat_t stat;

	// Operation sequencer.
	olist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, pointer arithmetic and result register.
	olist_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_opcode      (req.opcode),
		.req_value       (req.value),
		.req_position    (req.position),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_found_index (rsp.found_index),
		.rsp_entry_count (rsp.entry_count)
	);

endmodule

/* rtl/olist_checker.sv */
// Port-level checker for the ordered list block and its bind statement.
module olist_checker
	import olist_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       rsp_status,
	input logic [IDX_W-1:0] rsp_found_index,
	input logic [CNT_W-1:0] rsp_entry_count
);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// A full list reports the whole depth as its count.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == FULL_CNT)
		else $error("full status with a count other than the depth");

	// Only a successful operation may report a non-zero index.
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_found_index == '0)
		else $error("non-zero index on a failed operation");

	// The block takes one operation at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second transaction accepted straight after the first");

	// A stalled result holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_index) && $stable(rsp_entry_count))
		else $error("stalled result changed");

endmodule

bind ordered_list_insert_delete_search olist_checker #(
	.DEPTH (DEPTH)
) u_olist_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_index (rsp.found_index),
	.rsp_entry_count (rsp.entry_count)
);
